FILE: design/v4n_pkg.sv
package v4n_pkg;

    // Field and datapath widths
    localparam int MagW      = 32;
    localparam int LenW      = 33;
    localparam int SqW       = 64;
    localparam int SumW      = 66;
    localparam int EpsW      = 21;
    localparam int UnitW     = 32;
    localparam int RemW      = 64;

    // Pipeline depths
    localparam int RootSteps = 32;
    localparam int QuoSteps  = 31;
    localparam int SideDepth = 3 + RootSteps;
    localparam int VldDepth  = SideDepth + 1 + QuoSteps + 1;

    localparam logic [EpsW-1:0] EpsReset = 21'd10737;
    localparam logic [45:0]     OneQ30   = 46'h0000_4000_0000;

    // What the front end hands to each lane
    typedef struct packed {
        logic [MagW-1:0] mag;
        logic            neg;
        logic [LenW-1:0] dvs;
        logic            tiny;
    } t_lane_in;

endpackage

FILE: design/v4n_isqrt.sv
module v4n_isqrt (
    input  logic                       i_clk,
    input  logic                       i_adv,
    input  logic [v4n_pkg::SqW:0]      i_sum,
    output logic [v4n_pkg::LenW-1:0]   o_len
);
    import v4n_pkg::*;

    logic [RemW-1:0] r_rem  [RootSteps];
    logic [31:0]     r_root [RootSteps];
    logic            r_ovf  [RootSteps];

    // One root bit per stage, most significant first
    for (genvar s = 0; s < RootSteps; s++) begin : g_step
        localparam int J = RootSteps - 1 - s;
        logic [RemW-1:0] rem_in;
        logic [31:0]     root_in;
        logic            ovf_in;
        logic [SumW-1:0] trial;

        if (s == 0) begin : g_first
            assign rem_in  = i_sum[SqW-1:0];
            assign root_in = '0;
            assign ovf_in  = i_sum[SqW];
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign ovf_in  = r_ovf[s-1];
        end

        assign trial = ({34'd0, root_in} << (J + 1)) + (66'd1 << (2 * J));

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_ovf[s] <= ovf_in;
                if ({2'b00, rem_in} >= trial) begin
                    r_rem[s]  <= rem_in - trial[RemW-1:0];
                    r_root[s] <= root_in | (32'd1 << J);
                end else begin
                    r_rem[s]  <= rem_in;
                    r_root[s] <= root_in;
                end
            end
        end
    end

    // Full-scale sum has the exact root 2^32
    assign o_len = r_ovf[RootSteps-1] ? {1'b1, 32'd0} : {1'b0, r_root[RootSteps-1]};

endmodule

FILE: design/v4n_lane.sv
module v4n_lane (
    input  logic                       i_clk,
    input  logic                       i_adv,
    input  logic [v4n_pkg::EpsW-1:0]   i_eps,
    input  v4n_pkg::t_lane_in          i_lane,
    output logic [v4n_pkg::UnitW-1:0]  o_unit,
    output logic                       o_tiny
);
    import v4n_pkg::*;

    logic [RemW-1:0]  r_rem  [QuoSteps];
    logic [30:0]      r_quo  [QuoSteps];
    t_lane_in         r_info [QuoSteps];
    logic [UnitW-1:0] r_unit;
    logic             r_tiny;

    // Restoring division, one quotient bit per stage
    for (genvar s = 0; s < QuoSteps; s++) begin : g_step
        localparam int K = QuoSteps - 1 - s;
        logic [RemW-1:0] rem_in;
        logic [30:0]     quo_in;
        t_lane_in        info_in;
        logic [RemW-1:0] shifted;

        if (s == 0) begin : g_first
            assign rem_in  = {2'b00, i_lane.mag, 30'd0};
            assign quo_in  = '0;
            assign info_in = i_lane;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign quo_in  = r_quo[s-1];
            assign info_in = r_info[s-1];
        end

        assign shifted = {31'd0, info_in.dvs} << K;

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_info[s] <= info_in;
                if (rem_in >= shifted) begin
                    r_rem[s] <= rem_in - shifted;
                    r_quo[s] <= quo_in | (31'd1 << K);
                end else begin
                    r_rem[s] <= rem_in;
                    r_quo[s] <= quo_in;
                end
            end
        end
    end

    // Pick rescale or quotient, saturate, drop small values, restore sign
    t_lane_in    last;
    logic [45:0] qv;
    logic [30:0] sat;
    logic [30:0] kept;
    logic [31:0] mag_out;

    assign last    = r_info[QuoSteps-1];
    assign qv      = last.tiny ? {last.mag, 14'd0} : {15'd0, r_quo[QuoSteps-1]};
    assign sat     = (qv > OneQ30) ? OneQ30[30:0] : qv[30:0];
    assign kept    = (sat < {10'd0, i_eps}) ? 31'd0 : sat;
    assign mag_out = {1'b0, kept};

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_unit <= last.neg ? (32'd0 - mag_out) : mag_out;
            r_tiny <= last.tiny;
        end
    end

    assign o_unit = r_unit;
    assign o_tiny = r_tiny;

endmodule

FILE: design/vector4_normalize.sv
// Normalises one signed Q16.16 4-vector per clock, when not stalled, to signed Q1.30
// unit components. Fully pipelined: an item is taken every cycle while not stalled and
// passes through the 32-stage square-root pipeline and then the 31-stage divider in
// each of the four component lanes. The pipeline stalls as a whole only while a finished
// result is held at the output. The user must write epsilon_threshold through i_cfg_we /
// i_cfg_wdata only while the block is idle; the block itself does not enforce this.
module vector4_normalize (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [v4n_pkg::EpsW-1:0]   i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [31:0]                i_comp_x,
    input  logic [31:0]                i_comp_y,
    input  logic [31:0]                i_comp_z,
    input  logic [31:0]                i_comp_w,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [31:0]                o_unit_x,
    output logic [31:0]                o_unit_y,
    output logic [31:0]                o_unit_z,
    output logic [31:0]                o_unit_w,
    output logic                       o_tiny_length
);
    import v4n_pkg::*;

    logic            adv;
    logic [EpsW-1:0] r_eps;
    logic            r_vld [VldDepth];
    logic [MagW-1:0] r_mag [SideDepth][4];
    logic            r_neg [SideDepth][4];
    logic [SqW-1:0]  r_sq  [4];
    logic [SumW-1:0] r_sum;
    logic [LenW-1:0] len;
    t_lane_in        r_lane [4];
    logic [31:0]     lane_unit [4];
    logic            lane_tiny [4];
    logic [31:0]     comp [4];
    logic            r_out_valid;
    logic [31:0]     r_out_unit [4];
    logic            r_out_tiny;

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;
    assign comp[0] = i_comp_x;
    assign comp[1] = i_comp_y;
    assign comp[2] = i_comp_z;
    assign comp[3] = i_comp_w;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EpsReset;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VldDepth; k++) r_vld[k] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < VldDepth; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Take magnitudes and carry them alongside the root pipeline
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                r_neg[0][c] <= comp[c][31];
                r_mag[0][c] <= comp[c][31] ? (32'd0 - comp[c]) : comp[c];
            end
            for (int k = 1; k < SideDepth; k++) begin
                for (int c = 0; c < 4; c++) begin
                    r_neg[k][c] <= r_neg[k-1][c];
                    r_mag[k][c] <= r_mag[k-1][c];
                end
            end
        end
    end

    // Square each component, then sum
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) r_sq[c] <= r_mag[0][c] * r_mag[0][c];
            r_sum <= {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]}
                   + {2'b00, r_sq[3]};
        end
    end

    v4n_isqrt u_isqrt (
        .i_clk (i_clk),
        .i_adv (adv),
        .i_sum (r_sum[SqW:0]),
        .o_len (len)
    );

    // Length test and divisor choice
    logic tiny;
    assign tiny = ({len, 14'd0} <= {26'd0, r_eps}) || (len == '0);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                r_lane[c].mag  <= r_mag[SideDepth-1][c];
                r_lane[c].neg  <= r_neg[SideDepth-1][c];
                r_lane[c].tiny <= tiny;
                r_lane[c].dvs  <= tiny ? {{(LenW-1){1'b0}}, 1'b1} : len;
            end
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_lane
        v4n_lane u_lane (
            .i_clk  (i_clk),
            .i_adv  (adv),
            .i_eps  (r_eps),
            .i_lane (r_lane[c]),
            .o_unit (lane_unit[c]),
            .o_tiny (lane_tiny[c])
        );
    end

    // Merge lane results into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_vld[VldDepth-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) r_out_unit[c] <= lane_unit[c];
            r_out_tiny <= lane_tiny[0] & lane_tiny[1] & lane_tiny[2] & lane_tiny[3];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_unit_x      = r_out_unit[0];
    assign o_unit_y      = r_out_unit[1];
    assign o_unit_z      = r_out_unit[2];
    assign o_unit_w      = r_out_unit[3];
    assign o_tiny_length = r_out_tiny;

`ifndef SYNTHESIS
    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_unit_x) <= 32'sh4000_0000 &&
                     $signed(o_unit_x) >= -32'sh4000_0000))
        else $error("unit_x out of range");
    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_unit_w) <= 32'sh4000_0000 &&
                     $signed(o_unit_w) >= -32'sh4000_0000))
        else $error("unit_w out of range");
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall))
        else $error("input stalled without a held result");
    a_lane_tiny: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[VldDepth-1] |-> (lane_tiny[0] == lane_tiny[3]))
        else $error("lanes disagree on tiny length");
`endif

endmodule
